/* src/dbsec_pkg.sv */
// ----------------------------------------------------------------------------
// dbsec_pkg
// Shared types, constants and index helpers for the de Bruijn subset
// expansion cost block.
// ----------------------------------------------------------------------------
package dbsec_pkg;

	// graph size is fixed by the 64-bit mask field
	localparam int KMER_BITS = 6;
	localparam int NODES     = 1 << KMER_BITS;
	localparam int IDX_W     = KMER_BITS;
	localparam int MASK_W    = 64;
	localparam int FCOST_W   = 40;
	localparam int CFG_W     = 40;
	localparam int CFG_IDX_W = 2;
	localparam int GRP       = 8;

	localparam int DEF_MAX_WINDOW = 24;
	localparam int DEF_COST_BITS  = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COST_BUDGET = 2'd2;

	typedef struct packed {
		logic [FCOST_W-1:0] current_cost;
		logic [MASK_W-1:0]  subset_mask;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   added_kmer;
		logic [FCOST_W-1:0] new_cost;
		logic               within_budget;
		logic               adds_walks;
		logic               no_candidate;
		logic               could_be_final;
		logic               last;
	} out_item_t;

	// classified item between front and back
	typedef struct packed {
		logic [FCOST_W-1:0] cost;
		logic [MASK_W-1:0]  pend;   // k-mers still to try
		logic               full;
	} job_t;

	typedef struct packed {
		logic load;
		logic step;
		logic backward;
	} walk_ctl_t;

	// k clamped to 1..KMER_BITS
	function automatic logic [2:0] eff_kmer(input logic [2:0] k);
		logic [2:0] r;
		r = k;
		if (k == 3'd0)
			r = 3'd1;
		else if ({29'd0, k} > KMER_BITS)
			r = 3'(KMER_BITS);
		return r;
	endfunction

	function automatic logic [MASK_W-1:0] node_mask(input logic [2:0] kk);
		logic [6:0] n;
		n = 7'd1 << kk;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic [IDX_W-1:0] succ_idx(input int v, input int k);
		return IDX_W'((v << 1) & ((1 << k) - 1));
	endfunction

	function automatic logic [IDX_W-1:0] pred_idx(input int v, input int k);
		return IDX_W'((v >> 1) | (1 << (k - 1)));
	endfunction

endpackage

/* src/debruijn_subset_expansion_cost.sv */
// ----------------------------------------------------------------------------
// debruijn_subset_expansion_cost
// Expands one k-mer subset into one costed candidate per missing k-mer,
// counting de Bruijn walks that the new k-mer would add.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload        handshake
//  item      in         in_item_t      item_valid / item_stall
//  res       out        out_item_t     res_valid / res_stall
//  cfg       in         cfg_data (40)  cfg_wr_en, cfg_index
//
//  Each item runs one forward walk of S = window_len-1 steps (window
//  clamped), then a backward walk of S steps per missing k-mer, with the
//  scan passing over each k-mer already in the subset. The shared 64-lane
//  walk unit does one graph level per cycle; full subsets skip the walks.
//  Reset (arst_n low) empties the queue and loads k=6, w=8, budget=all ones.
//  A stalled result holds in the output register; the front queue keeps
//  taking items until its two entries are full.
//
module debruijn_subset_expansion_cost #(
	parameter int MAX_WINDOW = dbsec_pkg::DEF_MAX_WINDOW,
	parameter int COST_BITS  = dbsec_pkg::DEF_COST_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  dbsec_pkg::in_item_t            item_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output dbsec_pkg::out_item_t           res_data,
	input  logic                           cfg_wr_en,
	input  logic [dbsec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dbsec_pkg::CFG_W-1:0]    cfg_data
);

	logic [2:0]                    kmer_len_q;
	logic [4:0]                    window_len_q;
	logic [dbsec_pkg::CFG_W-1:0]   cost_budget_q;
	logic [2:0]                    kk;
	logic                          job_valid;
	logic                          job_take;
	dbsec_pkg::job_t               job;

	// configuration registers; write them only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q    <= 3'd6;
			window_len_q  <= 5'd8;
			cost_budget_q <= '1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dbsec_pkg::REG_KMER_LEN:    kmer_len_q    <= cfg_data[2:0];
				dbsec_pkg::REG_WINDOW_LEN:  window_len_q  <= cfg_data[4:0];
				dbsec_pkg::REG_COST_BUDGET: cost_budget_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign kk = dbsec_pkg::eff_kmer(kmer_len_q);

	// front: classify and queue
	dbsec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.kk         (kk),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.job_valid  (job_valid),
		.job        (job),
		.job_take   (job_take)
	);

	// back: walk counting and cost
	dbsec_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.COST_BITS  (COST_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.kk          (kk),
		.window_len  (window_len_q),
		.cost_budget (cost_budget_q),
		.job_valid   (job_valid),
		.job         (job),
		.job_take    (job_take),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data)
	);

endmodule

/* src/dbsec_front.sv */
// ----------------------------------------------------------------------------
// dbsec_front
// Accepts items, limits the mask to the graph, flags full subsets and
// queues the result in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dbsec_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         kk,
	input  logic               item_valid,
	output logic               item_stall,
	input  dbsec_pkg::in_item_t item_data,
	output logic               job_valid,
	output dbsec_pkg::job_t    job,
	input  logic               job_take
);

	dbsec_pkg::job_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	dbsec_pkg::job_t new_job;
	logic            push;
	logic            pop;

	always_comb begin
		new_job.cost = item_data.current_cost;
		new_job.pend = ~item_data.subset_mask & dbsec_pkg::node_mask(kk);
		new_job.full = (new_job.pend == '0);
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign job_valid  = (cnt_q != 2'd0);
	assign pop        = job_valid && job_take;
	assign job        = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= new_job;
	end

endmodule

/* src/dbsec_walk.sv */
// ----------------------------------------------------------------------------
// dbsec_walk
// One lane per graph node; each step every lane adds the walk counts of its
// two neighbors. ext gives the next-step sums without the avoid set.
// ----------------------------------------------------------------------------
module dbsec_walk #(
	parameter int MAX_WINDOW = dbsec_pkg::DEF_MAX_WINDOW
) (
	input  logic                      clk,
	input  logic [2:0]                kk,
	input  dbsec_pkg::walk_ctl_t      ctl,
	input  logic [dbsec_pkg::MASK_W-1:0] avoid,
	output logic [MAX_WINDOW:0]       ext [dbsec_pkg::NODES]
);

	localparam int CNT_W = MAX_WINDOW;

	logic [CNT_W-1:0] t_q [dbsec_pkg::NODES];

	for (genvar v = 0; v < dbsec_pkg::NODES; v++) begin : g_lane
		logic [CNT_W-1:0] fa, fb, ba, bb;

		always_comb begin
			fa = '0;
			fb = '0;
			bb = '0;
			ba = t_q[v >> 1];
			for (int j = 1; j <= dbsec_pkg::KMER_BITS; j++) begin
				if (kk == 3'(j)) begin
					fa = t_q[dbsec_pkg::succ_idx(v, j)];
					fb = t_q[dbsec_pkg::succ_idx(v, j) | 6'd1];
					bb = t_q[dbsec_pkg::pred_idx(v, j)];
				end
			end
			ext[v] = ctl.backward ? ({1'b0, ba} + {1'b0, bb}) : ({1'b0, fa} + {1'b0, fb});
		end

		always_ff @(posedge clk) begin
			if (ctl.load)
				t_q[v] <= avoid[v] ? '0 : CNT_W'(1);
			else if (ctl.step)
				t_q[v] <= avoid[v] ? '0 : ext[v][CNT_W-1:0];
		end
	end

endmodule

/* src/dbsec_back.sv */
// ----------------------------------------------------------------------------
// dbsec_back
// Runs the forward walk table once per non-full item, then one backward table per
// candidate k-mer. Forward counts sit in a shift chain kept aligned with the
// scan, backward counts are picked through a registered tree. Forms the
// saturated cost and holds each result in an output register.
// ----------------------------------------------------------------------------
module dbsec_back #(
	parameter int MAX_WINDOW = dbsec_pkg::DEF_MAX_WINDOW,
	parameter int COST_BITS  = dbsec_pkg::DEF_COST_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          kk,
	input  logic [4:0]          window_len,
	input  logic [dbsec_pkg::CFG_W-1:0] cost_budget,
	input  logic                job_valid,
	input  dbsec_pkg::job_t     job,
	output logic                job_take,
	output logic                res_valid,
	input  logic                res_stall,
	output dbsec_pkg::out_item_t res_data
);

	localparam int EXT_W = MAX_WINDOW + 1;
	localparam int SW    = ((COST_BITS > EXT_W) ? COST_BITS : EXT_W) + 1;
	localparam int NG    = dbsec_pkg::NODES / dbsec_pkg::GRP;
	localparam int FCW   = dbsec_pkg::FCOST_W;
	localparam logic [COST_BITS-1:0] TOP = {COST_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_FWD_LOAD, ST_FWD_STEP, ST_FWD_SAVE, ST_SCAN, ST_BW_LOAD,
		ST_BW_STEP, ST_SEL1, ST_SEL2, ST_ADD1, ST_ADD2, ST_EMIT, ST_EMIT_FULL
	} state_t;

	state_t                        state_q;
	logic [4:0]                    step_q;
	logic [dbsec_pkg::IDX_W-1:0]   x_q;
	logic                          dir_q;
	logic                          final_ok_q;
	logic [dbsec_pkg::MASK_W-1:0]  pend_q;
	logic [dbsec_pkg::MASK_W-1:0]  pend0_q;
	logic [COST_BITS-1:0]          cost_q;
	logic [COST_BITS-1:0]          c0_q, c1_q, c2_q;
	logic [EXT_W-1:0]              pre_q, suf_q;
	logic [EXT_W-1:0]              fw_q [dbsec_pkg::NODES];
	logic [EXT_W-1:0]              suf_grp_s1 [NG];
	logic [EXT_W-1:0]              ext [dbsec_pkg::NODES];
	dbsec_pkg::out_item_t          res_q;
	logic                          res_valid_q;

	dbsec_pkg::walk_ctl_t          ctl;
	logic [dbsec_pkg::MASK_W-1:0]  avoid;
	logic [4:0]                    steps;
	logic                          out_free;
	logic                          emit_fire;
	logic                          fw_shift;
	logic [dbsec_pkg::IDX_W-1:0]   km;
	logic                          corner;
	logic [SW-1:0]                 sum_a, sum_b;
	logic                          in_budget, adds, last_c;

	// walk steps = clamped window minus one
	always_comb begin
		if (window_len == 5'd0)
			steps = 5'd0;
		else if ({1'b0, window_len} > 6'(MAX_WINDOW))
			steps = 5'(MAX_WINDOW - 1);
		else
			steps = window_len - 5'd1;
	end

	assign km        = 6'((7'd1 << kk) - 7'd1);
	assign corner    = (x_q == '0) || (x_q == km);
	assign sum_a     = SW'(c0_q) + SW'(pre_q);
	assign sum_b     = SW'(c1_q) + SW'(suf_q);
	assign in_budget = (64'(c2_q) <= 64'(cost_budget));
	assign adds      = (pre_q != '0) || (suf_q != '0);
	assign last_c    = (pend_q == '0);
	assign out_free  = !res_valid_q || !res_stall;
	assign emit_fire = ((state_q == ST_EMIT) || (state_q == ST_EMIT_FULL)) && out_free;
	assign job_take  = (state_q == ST_IDLE);

	// forward chain moves one place each time the scan index advances
	assign fw_shift = ((state_q == ST_SCAN) && !pend_q[x_q]) ||
		((state_q == ST_EMIT) && out_free);

	assign ctl.load     = (state_q == ST_FWD_LOAD) || (state_q == ST_BW_LOAD);
	assign ctl.step     = (state_q == ST_FWD_STEP) || (state_q == ST_BW_STEP);
	assign ctl.backward = dir_q;
	assign avoid        = ~pend0_q | (dir_q ? (64'd1 << x_q) : 64'd0);

	dbsec_walk #(.MAX_WINDOW(MAX_WINDOW)) u_walk (
		.clk   (clk),
		.kk    (kk),
		.ctl   (ctl),
		.avoid (avoid),
		.ext   (ext)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			x_q         <= '0;
			dir_q       <= 1'b0;
			final_ok_q  <= 1'b1;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (emit_fire)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						pend_q     <= job.pend;
						dir_q      <= 1'b0;
						final_ok_q <= 1'b1;
						x_q        <= '0;
						state_q    <= job.full ? ST_EMIT_FULL : ST_FWD_LOAD;
					end
				end
				ST_FWD_LOAD: begin
					step_q  <= steps;
					state_q <= (steps == 5'd0) ? ST_FWD_SAVE : ST_FWD_STEP;
				end
				ST_FWD_STEP: begin
					step_q <= step_q - 5'd1;
					if (step_q == 5'd1)
						state_q <= ST_FWD_SAVE;
				end
				ST_FWD_SAVE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (pend_q[x_q]) begin
						dir_q   <= 1'b1;
						state_q <= ST_BW_LOAD;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				ST_BW_LOAD: begin
					pend_q[x_q] <= 1'b0;
					step_q      <= steps;
					state_q     <= (steps == 5'd0) ? ST_SEL1 : ST_BW_STEP;
				end
				ST_BW_STEP: begin
					step_q <= step_q - 5'd1;
					if (step_q == 5'd1)
						state_q <= ST_SEL1;
				end
				ST_SEL1: state_q <= ST_SEL2;
				ST_SEL2: state_q <= ST_ADD1;
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						res_q.added_kmer     <= x_q;
						res_q.new_cost       <= FCW'(c2_q);
						res_q.within_budget  <= in_budget;
						res_q.adds_walks     <= adds;
						res_q.no_candidate   <= 1'b0;
						res_q.could_be_final <= last_c && final_ok_q && in_budget && !adds;
						res_q.last           <= last_c;
						final_ok_q           <= final_ok_q && in_budget && !adds;
						x_q                  <= x_q + 1'b1;
						state_q              <= last_c ? ST_IDLE : ST_SCAN;
					end
				end
				ST_EMIT_FULL: begin
					if (out_free) begin
						res_q.added_kmer     <= '0;
						res_q.new_cost       <= '0;
						res_q.within_budget  <= 1'b0;
						res_q.adds_walks     <= 1'b0;
						res_q.no_candidate   <= 1'b1;
						res_q.could_be_final <= 1'b1;
						res_q.last           <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			pend0_q <= job.pend;
			cost_q  <= COST_BITS'(job.cost);
		end
		if (state_q == ST_FWD_SAVE) begin
			for (int v = 0; v < dbsec_pkg::NODES; v++)
				fw_q[v] <= ext[v];
		end else if (fw_shift) begin
			for (int v = 0; v < dbsec_pkg::NODES - 1; v++)
				fw_q[v] <= fw_q[v + 1];
			fw_q[dbsec_pkg::NODES - 1] <= '0;
		end
		if (state_q == ST_SEL1) begin
			for (int g = 0; g < NG; g++)
				suf_grp_s1[g] <= ext[{3'(g), x_q[2:0]}];
		end
		if (state_q == ST_SEL2) begin
			pre_q <= fw_q[0];
			suf_q <= suf_grp_s1[x_q[5:3]];
			c0_q  <= (corner && cost_q != '0) ? cost_q - 1'b1 : cost_q;
		end
		if (state_q == ST_ADD1)
			c1_q <= (sum_a > SW'(TOP)) ? TOP : sum_a[COST_BITS-1:0];
		if (state_q == ST_ADD2)
			c2_q <= (sum_b > SW'(TOP)) ? TOP : sum_b[COST_BITS-1:0];
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

/* src/dbsec_checker.sv */
// ----------------------------------------------------------------------------
// dbsec_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module dbsec_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_stall,
	input dbsec_pkg::out_item_t res_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.no_candidate |->
			res_data.last && res_data.could_be_final)
		else $error("no-candidate item not final");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.could_be_final |-> res_data.last)
		else $error("could_be_final off last item");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.no_candidate |->
			res_data.new_cost == '0 && !res_data.adds_walks)
		else $error("no-candidate fields not zero");

endmodule

bind debruijn_subset_expansion_cost dbsec_checker u_dbsec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

/* tb/debruijn_subset_expansion_cost_test.sv */
// ----------------------------------------------------------------------------
// debruijn_subset_expansion_cost_test
// Self-checking bench: subset items stream in with random bursts and gaps,
// results drain under a shifting stall pattern, and every candidate is
// compared field by field against an in-bench walk-counting predictor.
// ----------------------------------------------------------------------------
module debruijn_subset_expansion_cost_test;

	localparam int          LIMIT    = 3000000;
	localparam logic [39:0] COST_TOP = 40'hFF_FFFF_FFFF;

	// count table indexed by graph node
	typedef bit [63:0] walk_tab_t [64];

	logic                            clk;
	logic                            arst_n;
	logic                            item_valid;
	logic                            item_stall;
	dbsec_pkg::in_item_t             item_data;
	logic                            res_valid;
	logic                            res_stall;
	dbsec_pkg::out_item_t            res_data;
	logic                            cfg_wr_en;
	logic [dbsec_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dbsec_pkg::CFG_W-1:0]     cfg_data;

	debruijn_subset_expansion_cost dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// bench copy of the registers, raw as written
	logic [2:0]  kmer_reg;
	logic [4:0]  window_reg;
	logic [39:0] budget_reg;

	dbsec_pkg::in_item_t  subsets_to_send[$];
	dbsec_pkg::out_item_t candidates_due[$];

	int  fail_count;
	int  cycle_count;
	bit  accept_seen;
	int  burst_left;
	int  gap_left;
	int  stall_mode;

	always #5 clk = ~clk;

	// number of walks of 'steps' steps from each node avoiding 'avoid'
	function automatic walk_tab_t count_walks(bit [63:0] avoid, int k, int steps, bit back);
		walk_tab_t t, nx;
		int n, a, b;
		n = 1 << k;
		for (int v = 0; v < 64; v++) begin
			t[v] = (v < n && !avoid[v]) ? 64'd1 : 64'd0;
			nx[v] = 64'd0;
		end
		for (int s = 0; s < steps; s++) begin
			for (int v = 0; v < n; v++) begin
				if (avoid[v]) begin
					nx[v] = 64'd0;
				end else begin
					if (back) begin
						a = v >> 1;
						b = a | (1 << (k - 1));
					end else begin
						a = (v << 1) & (n - 1);
						b = a | 1;
					end
					nx[v] = t[a] + t[b];
				end
			end
			for (int v = 0; v < n; v++)
				t[v] = nx[v];
		end
		return t;
	endfunction

	function automatic bit [63:0] sat_cost(bit [63:0] a, bit [63:0] b);
		bit [63:0] top;
		top = {24'd0, COST_TOP};
		if (a > top || b > top - a)
			return top;
		return a + b;
	endfunction

	// one accepted subset -> its candidate list, appended to candidates_due
	function automatic void expand_subset(dbsec_pkg::in_item_t it);
		int k, w, n, steps, km, nk, pk;
		walk_tab_t fw, bw;
		bit [63:0] mask, pre, suf, c;
		bit final_ok, have_prev;
		dbsec_pkg::out_item_t prev, cur;
		k = (kmer_reg == 3'd0) ? 1 : (kmer_reg > 3'd6) ? 6 : int'(kmer_reg);
		w = (window_reg == 5'd0) ? 1 : (window_reg > 5'd24) ? 24 : int'(window_reg);
		n = 1 << k;
		km = n - 1;
		steps = w - 1;
		mask = it.subset_mask;
		fw = count_walks(mask, k, steps, 1'b0);
		final_ok = 1'b1;
		have_prev = 1'b0;
		prev = '0;
		for (int x = 0; x < n; x++) begin
			if (!mask[x]) begin
				bw = count_walks(mask | (64'd1 << x), k, steps, 1'b1);
				nk = (x << 1) & km;
				pk = x >> 1;
				pre = fw[nk] + fw[nk | 1];
				suf = bw[pk] + bw[pk | (1 << (k - 1))];
				c = {24'd0, it.current_cost};
				// corner k-mers get one off, floored at zero
				if ((x == 0 || x == km) && c != 0)
					c = c - 1;
				c = sat_cost(c, pre);
				c = sat_cost(c, suf);
				cur = '0;
				cur.added_kmer = x[5:0];
				cur.new_cost = c[39:0];
				cur.within_budget = (c[39:0] <= budget_reg);
				cur.adds_walks = (pre != 0 || suf != 0);
				if (!cur.within_budget || cur.adds_walks)
					final_ok = 1'b0;
				if (have_prev)
					candidates_due = {candidates_due, prev};
				prev = cur;
				have_prev = 1'b1;
			end
		end
		if (!have_prev) begin
			// full subset: a lone marker result
			prev = '0;
			prev.no_candidate = 1'b1;
			prev.could_be_final = 1'b1;
		end else begin
			prev.could_be_final = final_ok;
		end
		prev.last = 1'b1;
		candidates_due = {candidates_due, prev};
	endfunction

	// ---- sender: bursts with random gaps, fed from subsets_to_send ----
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			expand_subset(item_data);
			accept_seen <= 1'b1;
		end
	end

	always @(negedge clk) begin
		accept_seen <= 1'b0;
		if (arst_n && (!item_valid || accept_seen)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				item_valid <= 1'b0;
			end else if (subsets_to_send.size() > 0) begin
				item_data <= subsets_to_send.pop_front();
				item_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 10);
					// about a third of bursts run straight into the next
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ---- receiver: one of four stall patterns, re-picked at random ----
	always @(negedge clk) begin
		if (cycle_count % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= (cycle_count % 3 == 0);
		endcase
	end

	// ---- result checker ----
	always @(posedge clk) begin
		dbsec_pkg::out_item_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (candidates_due.size() == 0) begin
				$error("unexpected result: added_kmer=%0d", res_data.added_kmer);
				fail_count++;
			end else begin
				exp_r = candidates_due.pop_front();
				if (res_data.added_kmer !== exp_r.added_kmer) begin
					$error("added_kmer exp %0d got %0d", exp_r.added_kmer, res_data.added_kmer);
					fail_count++;
				end
				if (res_data.new_cost !== exp_r.new_cost) begin
					$error("new_cost exp %0d got %0d", exp_r.new_cost, res_data.new_cost);
					fail_count++;
				end
				if (res_data.within_budget !== exp_r.within_budget) begin
					$error("within_budget exp %0b got %0b", exp_r.within_budget,
						res_data.within_budget);
					fail_count++;
				end
				if (res_data.adds_walks !== exp_r.adds_walks) begin
					$error("adds_walks exp %0b got %0b", exp_r.adds_walks, res_data.adds_walks);
					fail_count++;
				end
				if (res_data.no_candidate !== exp_r.no_candidate) begin
					$error("no_candidate exp %0b got %0b", exp_r.no_candidate,
						res_data.no_candidate);
					fail_count++;
				end
				if (res_data.could_be_final !== exp_r.could_be_final) begin
					$error("could_be_final exp %0b got %0b", exp_r.could_be_final,
						res_data.could_be_final);
					fail_count++;
				end
				if (res_data.last !== exp_r.last) begin
					$error("last exp %0b got %0b", exp_r.last, res_data.last);
					fail_count++;
				end
			end
		end
	end

	// ---- watchdog ----
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("debruijn_subset_expansion_cost_test: FAIL");
			$finish;
		end
	end

	// block is idle once nothing is queued, driven or owed
	task automatic wait_drained();
		while (subsets_to_send.size() != 0 || item_valid || candidates_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [dbsec_pkg::CFG_IDX_W-1:0] idx, logic [39:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == dbsec_pkg::REG_KMER_LEN)
			kmer_reg = val[2:0];
		else if (idx == dbsec_pkg::REG_WINDOW_LEN)
			window_reg = val[4:0];
		else if (idx == dbsec_pkg::REG_COST_BUDGET)
			budget_reg = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(logic [39:0] k, logic [39:0] w, logic [39:0] budget);
		write_reg(dbsec_pkg::REG_KMER_LEN, k);
		write_reg(dbsec_pkg::REG_WINDOW_LEN, w);
		write_reg(dbsec_pkg::REG_COST_BUDGET, budget);
	endtask

	function automatic int eff_nodes();
		return 1 << ((kmer_reg == 3'd0) ? 1 : (kmer_reg > 3'd6) ? 6 : int'(kmer_reg));
	endfunction

	function automatic logic [39:0] rand_cost();
		case ($urandom_range(0, 5))
			0: return 40'd0;
			1: return 40'd1;
			2: return COST_TOP - 40'($urandom_range(0, 3));
			default: return {$urandom(), $urandom()} & COST_TOP;
		endcase
	endfunction

	// near-full or sparse masks half the time, which give few or many candidates
	function automatic logic [63:0] rand_mask();
		logic [63:0] m;
		int n;
		n = eff_nodes();
		case ($urandom_range(0, 9))
			0, 1: m = {$urandom(), $urandom()};
			2, 3, 4: begin
				m = ~64'd0;
				repeat ($urandom_range(1, 4)) m[$urandom_range(0, n - 1)] = 1'b0;
			end
			5, 6: begin
				m = 64'd0;
				repeat ($urandom_range(1, 4)) m[$urandom_range(0, n - 1)] = 1'b1;
				m = m | ({$urandom(), $urandom()} & ~((64'd1 << n) - 1) & {64{n < 64}});
			end
			7: m = ~64'd0;
			8: m = 64'd0;
			default: m = {$urandom(), $urandom()} | {$urandom(), $urandom()};
		endcase
		return m;
	endfunction

	task automatic queue_subset(logic [39:0] cost, logic [63:0] mask);
		dbsec_pkg::in_item_t it;
		it.current_cost = cost;
		it.subset_mask = mask;
		subsets_to_send = {subsets_to_send, it};
	endtask

	initial begin
		logic [39:0] w_pick, b_pick;
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_data = '0;
		res_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		cycle_count = 0;
		accept_seen = 1'b0;
		burst_left = 4;
		gap_left = 0;
		stall_mode = 0;
		kmer_reg = 3'd6;
		window_reg = 5'd8;
		budget_reg = COST_TOP;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: full set, empty set, cost extremes, corners
		queue_subset(40'd5, ~64'd0);
		queue_subset(40'd0, 64'd0);
		queue_subset(COST_TOP, 64'd0);
		queue_subset(40'd0, ~64'd1);
		queue_subset(40'd1, ~(64'd1 << 63));
		queue_subset(COST_TOP, 64'h5555_5555_5555_5555);
		queue_subset(40'h55_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		wait_drained();

		// directed, small graph with short windows and a tight budget
		configure(40'd2, 40'd3, 40'd4);
		queue_subset(40'd0, 64'd0);
		queue_subset(40'd1, 64'hFFFF_FFFF_FFFF_FFF0);
		queue_subset(40'd3, 64'hFFFF_FFFF_FFFF_FFF6);
		queue_subset(40'd10, 64'h0000_0000_0000_000F);
		wait_drained();
		// out-of-range k and w: clamp low
		configure(40'd0, 40'd0, 40'd0);
		queue_subset(40'd0, 64'd0);
		queue_subset(40'd1, 64'h2);
		queue_subset(40'd7, ~64'd0);
		wait_drained();
		// clamp high; one window-24 sweep on the full graph
		configure(40'd7, 40'd31, COST_TOP);
		queue_subset(COST_TOP - 40'd1, 64'd0);
		queue_subset(40'd100, 64'hF0F0_0F0F_F0F0_0F0F);
		wait_drained();
		configure(40'd1, 40'd1, 40'd1);
		queue_subset(40'd0, 64'd0);
		queue_subset(40'd2, 64'h1);
		queue_subset(40'd1, 64'h2);
		wait_drained();

		// sender pauses until each item is fully answered
		configure(40'd3, 40'd4, 40'd50);
		repeat (6) begin
			queue_subset(rand_cost(), rand_mask());
			wait_drained();
		end

		// random phases: mostly short windows, now and then long ones
		repeat (11) begin
			if ($urandom_range(0, 4) == 0)
				w_pick = 40'($urandom_range(17, 31));
			else
				w_pick = 40'($urandom_range(0, 9));
			case ($urandom_range(0, 3))
				0: b_pick = 40'd0;
				1: b_pick = COST_TOP;
				2: b_pick = 40'($urandom_range(0, 200));
				default: b_pick = {$urandom(), $urandom()} & COST_TOP;
			endcase
			configure(40'($urandom_range(0, 7)), w_pick, b_pick);
			repeat ((w_pick > 16 && eff_nodes() > 16) ? 4 : 23)
				queue_subset(rand_cost(), rand_mask());
			wait_drained();
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("debruijn_subset_expansion_cost_test: PASS");
		end else begin
			$display("debruijn_subset_expansion_cost_test: FAIL");
		end
		$finish;
	end

endmodule
